[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the deque checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside of reset.
`define DEQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("deque check failed");

// Flag a condition that must never show on a rising edge outside of reset.
`define DEQ_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("deque forbidden condition seen");

`endif

[src/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, codes and defaults of the double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

    localparam int DEPTH_DEF      = 256;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int OP_W           = 3;
    localparam int POS_W          = 8;
    localparam int STATUS_W       = 2;

    // Operation codes of an input word; the unused code is ignored.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_READ_AT    = 3'd4,
        OP_INSERT_AT  = 3'd5,
        OP_ERASE_AT   = 3'd6
    } t_op;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD_WAIT,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } t_state;

    // Memory address selection, in logical positions.
    typedef enum logic [2:0] {
        A_FRONT,
        A_FRONT_NEW,
        A_BACK,
        A_LAST,
        A_POS,
        A_IDX,
        A_IDX_M1,
        A_IDX_P1
    } t_asel;

    typedef enum logic [0:0] {
        W_DATA,
        W_RDATA
    } t_wsrc;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_CNT,
        IDX_POS,
        IDX_INC,
        IDX_DEC
    } t_idx_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef enum logic [1:0] {
        HEAD_HOLD,
        HEAD_INC,
        HEAD_DEC
    } t_head_op;

    // Commands from controller to datapath.
    typedef struct packed {
        logic     load_item;
        logic     rd_en;
        logic     wr_en;
        t_asel    asel;
        t_wsrc    wsrc;
        t_idx_op  idx_op;
        t_cnt_op  cnt_op;
        t_head_op head_op;
        logic     res_load;
        t_status  res_status;
        logic     res_cap;
        logic     out_load;
    } t_dp_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        t_op  op;
        logic empty;
        logic full;
        logic pos_ge_cnt;
        logic pos_gt_cnt;
        logic idx_gt_pos;
        logic idx_p1_lt_cnt;
        logic out_busy;
    } t_dp_stat;

endpackage

`default_nettype wire

[src/deq_dp.sv]
// ----------------------------------------------------------------------------
// deq_dp
// Deque datapath: element memory, head and count registers, shift index,
// result and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_dp #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [deq_pkg::OP_W-1:0]          i_op,
    input  wire logic [deq_pkg::POS_W-1:0]         i_position,
    input  wire logic signed [DATA_WIDTH-1:0]      i_data_in,
    input  wire deq_pkg::t_dp_cmd                  i_cmd,
    output deq_pkg::t_dp_stat                      o_stat,
    input  wire logic                              i_out_stall,
    output logic                                   o_valid,
    output logic [deq_pkg::STATUS_W-1:0]           o_status,
    output logic signed [DATA_WIDTH-1:0]           o_data_out,
    output logic [$clog2(DEPTH+1)-1:0]             o_count_out
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > deq_pkg::POS_W) ? CW : deq_pkg::POS_W;

    logic [DATA_WIDTH-1:0]          r_mem [DEPTH];
    logic [DATA_WIDTH-1:0]          r_rdata;

    deq_pkg::t_op                   r_op;
    logic [deq_pkg::POS_W-1:0]      r_pos;
    logic [DATA_WIDTH-1:0]          r_data;
    logic [AW-1:0]                  r_head, n_head;
    logic [CW-1:0]                  r_count, n_count;
    logic [CW-1:0]                  r_idx, n_idx;
    deq_pkg::t_status               r_res_status;
    logic [DATA_WIDTH-1:0]          r_res_data;
    logic                           r_out_valid;
    deq_pkg::t_status               r_out_status;
    logic [DATA_WIDTH-1:0]          r_out_data;
    logic [CW-1:0]                  r_out_count;

    logic [LW-1:0]                  cnt_l, pos_l, idx_l;
    logic [AW-1:0]                  head_dec, head_inc;
    logic [AW-1:0]                  addr;
    logic [DATA_WIDTH-1:0]          wdata;

    // Map a logical position to a physical slot; the sum stays below twice DEPTH.
    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] head,
                                             input logic [LW-1:0] logical);
        logic [LW:0] sum;
        sum = (LW+1)'(head) + (LW+1)'(logical);
        if (sum >= (LW+1)'(DEPTH)) begin
            sum = sum - (LW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign cnt_l = LW'(r_count);
    assign pos_l = LW'(r_pos);
    assign idx_l = LW'(r_idx);

    // Wrap the head pointer one slot either way.
    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;
    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;

    // Select the memory address.
    always_comb begin
        unique case (i_cmd.asel)
            deq_pkg::A_FRONT:     addr = r_head;
            deq_pkg::A_FRONT_NEW: addr = head_dec;
            deq_pkg::A_BACK:      addr = f_slot(r_head, cnt_l);
            deq_pkg::A_LAST:      addr = f_slot(r_head, cnt_l - 1'b1);
            deq_pkg::A_POS:       addr = f_slot(r_head, pos_l);
            deq_pkg::A_IDX:       addr = f_slot(r_head, idx_l);
            deq_pkg::A_IDX_M1:    addr = f_slot(r_head, idx_l - 1'b1);
            deq_pkg::A_IDX_P1:    addr = f_slot(r_head, idx_l + 1'b1);
            default:              addr = r_head;
        endcase
    end

    assign wdata = (i_cmd.wsrc == deq_pkg::W_RDATA) ? r_rdata : r_data;

    // Write and read the element memory.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[addr] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[addr];
        end
    end

    // Next head, count and shift index.
    always_comb begin
        unique case (i_cmd.head_op)
            deq_pkg::HEAD_INC: n_head = head_inc;
            deq_pkg::HEAD_DEC: n_head = head_dec;
            default:           n_head = r_head;
        endcase
        unique case (i_cmd.cnt_op)
            deq_pkg::CNT_INC: n_count = r_count + 1'b1;
            deq_pkg::CNT_DEC: n_count = r_count - 1'b1;
            default:          n_count = r_count;
        endcase
        unique case (i_cmd.idx_op)
            deq_pkg::IDX_CNT: n_idx = r_count;
            deq_pkg::IDX_POS: n_idx = pos_l[CW-1:0];
            deq_pkg::IDX_INC: n_idx = r_idx + 1'b1;
            deq_pkg::IDX_DEC: n_idx = r_idx - 1'b1;
            default:          n_idx = r_idx;
        endcase
    end

    // Hold pointer state; clear it at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the item, the shift index and the result.
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.load_item) begin
            r_op   <= deq_pkg::t_op'(i_op);
            r_pos  <= i_position;
            r_data <= i_data_in;
        end
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            r_res_data   <= '0;
        end else if (i_cmd.res_cap) begin
            r_res_data <= r_rdata;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_data   <= r_res_data;
            r_out_count  <= r_count;
        end
    end

    // Report conditions to the controller.
    always_comb begin
        o_stat.op            = r_op;
        o_stat.empty         = (r_count == '0);
        o_stat.full          = (r_count == CW'(DEPTH));
        o_stat.pos_ge_cnt    = (pos_l >= cnt_l);
        o_stat.pos_gt_cnt    = (pos_l > cnt_l);
        o_stat.idx_gt_pos    = (idx_l > pos_l);
        o_stat.idx_p1_lt_cnt = (({1'b0, idx_l} + 1'b1) < {1'b0, cnt_l});
        o_stat.out_busy      = r_out_valid && i_out_stall;
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_out_status;
    assign o_data_out  = r_out_data;
    assign o_count_out = r_out_count;

endmodule

`default_nettype wire

[src/deq_ctrl.sv]
// ----------------------------------------------------------------------------
// deq_ctrl
// Deque controller: sequences end operations, reads and element shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire deq_pkg::t_dp_stat i_stat,
    output deq_pkg::t_dp_cmd       o_cmd,
    output logic                   o_busy
);

    deq_pkg::t_state r_state, n_state;

    // Hold the state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= deq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Decide next state and datapath commands.
    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.asel       = deq_pkg::A_FRONT;
        o_cmd.wsrc       = deq_pkg::W_DATA;
        o_cmd.idx_op     = deq_pkg::IDX_HOLD;
        o_cmd.cnt_op     = deq_pkg::CNT_HOLD;
        o_cmd.head_op    = deq_pkg::HEAD_HOLD;
        o_cmd.res_status = deq_pkg::ST_OK;

        unique case (r_state)
            deq_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = deq_pkg::S_EXEC;
                end
            end

            deq_pkg::S_EXEC: begin
                o_cmd.res_load = 1'b1;
                n_state        = deq_pkg::S_DONE;
                unique case (i_stat.op)
                    deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
                        if (i_stat.full) begin
                            o_cmd.res_status = deq_pkg::ST_FULL;
                        end else begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.cnt_op = deq_pkg::CNT_INC;
                            if (i_stat.op == deq_pkg::OP_PUSH_FRONT) begin
                                o_cmd.asel    = deq_pkg::A_FRONT_NEW;
                                o_cmd.head_op = deq_pkg::HEAD_DEC;
                            end else begin
                                o_cmd.asel = deq_pkg::A_BACK;
                            end
                        end
                    end
                    deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
                        if (i_stat.empty) begin
                            o_cmd.res_status = deq_pkg::ST_RANGE;
                        end else begin
                            o_cmd.rd_en = 1'b1;
                            o_cmd.asel  = (i_stat.op == deq_pkg::OP_POP_FRONT) ?
                                          deq_pkg::A_FRONT : deq_pkg::A_LAST;
                            n_state     = deq_pkg::S_RD_WAIT;
                        end
                    end
                    deq_pkg::OP_READ_AT, deq_pkg::OP_ERASE_AT: begin
                        if (i_stat.pos_ge_cnt) begin
                            o_cmd.res_status = deq_pkg::ST_RANGE;
                        end else begin
                            o_cmd.rd_en = 1'b1;
                            o_cmd.asel  = deq_pkg::A_POS;
                            n_state     = deq_pkg::S_RD_WAIT;
                        end
                    end
                    deq_pkg::OP_INSERT_AT: begin
                        // Range check comes before the full check.
                        if (i_stat.pos_gt_cnt) begin
                            o_cmd.res_status = deq_pkg::ST_RANGE;
                        end else if (i_stat.full) begin
                            o_cmd.res_status = deq_pkg::ST_FULL;
                        end else begin
                            o_cmd.idx_op = deq_pkg::IDX_CNT;
                            n_state      = deq_pkg::S_SHIFT_RD;
                        end
                    end
                    default: begin
                        // Unused op: report ok, change nothing.
                    end
                endcase
            end

            deq_pkg::S_RD_WAIT: begin
                o_cmd.res_cap = 1'b1;
                n_state       = deq_pkg::S_DONE;
                unique case (i_stat.op)
                    deq_pkg::OP_POP_FRONT: begin
                        o_cmd.head_op = deq_pkg::HEAD_INC;
                        o_cmd.cnt_op  = deq_pkg::CNT_DEC;
                    end
                    deq_pkg::OP_POP_BACK: begin
                        o_cmd.cnt_op = deq_pkg::CNT_DEC;
                    end
                    deq_pkg::OP_ERASE_AT: begin
                        o_cmd.idx_op = deq_pkg::IDX_POS;
                        n_state      = deq_pkg::S_SHIFT_RD;
                    end
                    default: begin
                    end
                endcase
            end

            deq_pkg::S_SHIFT_RD: begin
                if (i_stat.op == deq_pkg::OP_INSERT_AT) begin
                    if (i_stat.idx_gt_pos) begin
                        o_cmd.rd_en = 1'b1;
                        o_cmd.asel  = deq_pkg::A_IDX_M1;
                        n_state     = deq_pkg::S_SHIFT_WR;
                    end else begin
                        o_cmd.wr_en  = 1'b1;
                        o_cmd.asel   = deq_pkg::A_POS;
                        o_cmd.cnt_op = deq_pkg::CNT_INC;
                        n_state      = deq_pkg::S_DONE;
                    end
                end else begin
                    if (i_stat.idx_p1_lt_cnt) begin
                        o_cmd.rd_en = 1'b1;
                        o_cmd.asel  = deq_pkg::A_IDX_P1;
                        n_state     = deq_pkg::S_SHIFT_WR;
                    end else begin
                        o_cmd.cnt_op = deq_pkg::CNT_DEC;
                        n_state      = deq_pkg::S_DONE;
                    end
                end
            end

            deq_pkg::S_SHIFT_WR: begin
                // Move the word just read into the slot at the index.
                o_cmd.wr_en  = 1'b1;
                o_cmd.asel   = deq_pkg::A_IDX;
                o_cmd.wsrc   = deq_pkg::W_RDATA;
                o_cmd.idx_op = (i_stat.op == deq_pkg::OP_INSERT_AT) ?
                               deq_pkg::IDX_DEC : deq_pkg::IDX_INC;
                n_state      = deq_pkg::S_SHIFT_RD;
            end

            deq_pkg::S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = deq_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = deq_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != deq_pkg::S_IDLE);

endmodule

`default_nettype wire

[src/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue
// Fixed-capacity deque of signed words with end and indexed operations.
// ----------------------------------------------------------------------------
// Input channel i_valid/o_stall carries one word: op, position, data_in.
// Output channel o_valid/i_stall returns one result word per input word:
// status, data_out and the element count after the operation.
// Each word is worked on alone; o_stall is high from acceptance until its
// result is loaded into the output register. Pop and read_at take one
// memory read; insert_at moves the elements from the position to the back,
// and erase_at reads the element it removes and then moves the elements
// behind it; each move is a read and a write of the single-port element
// memory. The result shows on o_valid at the edge that frees the input side.
// Reset empties the queue (head and count to zero); memory is not cleared.
// While the receiver stalls, the result holds and the next word may still
// be taken; its own result waits until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [deq_pkg::OP_W-1:0]      i_op,
    input  wire logic [deq_pkg::POS_W-1:0]     i_position,
    input  wire logic signed [DATA_WIDTH-1:0]  i_data_in,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [deq_pkg::STATUS_W-1:0]       o_status,
    output logic signed [DATA_WIDTH-1:0]       o_data_out,
    output logic [$clog2(DEPTH+1)-1:0]         o_count_out
);

    deq_pkg::t_dp_cmd  cmd;
    deq_pkg::t_dp_stat stat;

    deq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_stall)
    );

    deq_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (i_op),
        .i_position  (i_position),
        .i_data_in   (i_data_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_stall (i_stall),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_data_out  (o_data_out),
        .o_count_out (o_count_out)
    );

endmodule

`default_nettype wire

[src/deq_checker.sv]
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks of the deque, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module deq_checker #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_valid,
    input wire logic                          o_stall,
    input wire logic                          o_valid,
    input wire logic                          i_stall,
    input wire logic [deq_pkg::STATUS_W-1:0]  o_status,
    input wire logic signed [DATA_WIDTH-1:0]  o_data_out,
    input wire logic [$clog2(DEPTH+1)-1:0]    o_count_out
);

    localparam int CW = $clog2(DEPTH + 1);

    // A stalled result holds.
    `DEQ_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_data_out) && $stable(o_count_out))

    // The count never passes the capacity.
    `DEQ_ASSERT(a_count_cap, i_clk, i_rst_n, o_valid |-> o_count_out <= CW'(DEPTH))

    // A failed operation returns zero data.
    `DEQ_NEVER(a_fail_zero, i_clk, i_rst_n, o_valid && o_status != deq_pkg::ST_OK && o_data_out != '0)

    // Only defined status codes appear.
    `DEQ_NEVER(a_status_code, i_clk, i_rst_n, o_valid && o_status != deq_pkg::ST_OK && o_status != deq_pkg::ST_RANGE && o_status != deq_pkg::ST_FULL)

    // An accepted word blocks the input for at least the next cycle.
    `DEQ_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall |=> o_stall)

endmodule

bind double_ended_queue deq_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_deq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_status    (o_status),
    .o_data_out  (o_data_out),
    .o_count_out (o_count_out)
);

`default_nettype wire

[test/double_ended_queue_chk.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_chk
// Watches both channels of the deque, predicts every result word from its
// own copy of the store, head and count, and compares field by field.
// ----------------------------------------------------------------------------
module double_ended_queue_chk #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF,
    parameter int DW    = deq_pkg::DATA_WIDTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic [deq_pkg::OP_W-1:0]         i_op,
    input  logic [deq_pkg::POS_W-1:0]        i_position,
    input  logic signed [DW-1:0]             i_data_in,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic [deq_pkg::STATUS_W-1:0]     i_status,
    input  logic signed [DW-1:0]             i_data_out,
    input  logic [CNT_W-1:0]                 i_count_out,
    output int                               o_error_count,
    output int                               o_awaited,
    output int                               o_fill_level
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OP_W = deq_pkg::OP_W;

    typedef struct {
        deq_pkg::t_status      status;
        logic signed [DW-1:0]  data;
        logic [CNT_W-1:0]      count;
    } t_deque_result;

    // Shadow of the circular store
    logic signed [DW-1:0] shadow_store [DEPTH];
    int                   front_slot;
    int                   fill_level;

    t_deque_result awaited_results [$];

    function automatic int slot_of(input int logical);
        return (front_slot + logical) % DEPTH;
    endfunction

    // Apply one word to the shadow deque and return its result word
    function automatic t_deque_result apply_deque_op(
        input logic [OP_W-1:0]      op,
        input int                   pos,
        input logic signed [DW-1:0] word
    );
        t_deque_result res;
        int            k;
        res.status = deq_pkg::ST_OK;
        res.data   = '0;
        case (op)
            deq_pkg::OP_PUSH_FRONT: begin
                if (fill_level >= DEPTH) begin
                    res.status = deq_pkg::ST_FULL;
                end else begin
                    front_slot = (front_slot + DEPTH - 1) % DEPTH;
                    shadow_store[front_slot] = word;
                    fill_level++;
                end
            end
            deq_pkg::OP_PUSH_BACK: begin
                if (fill_level >= DEPTH) begin
                    res.status = deq_pkg::ST_FULL;
                end else begin
                    shadow_store[slot_of(fill_level)] = word;
                    fill_level++;
                end
            end
            deq_pkg::OP_POP_FRONT: begin
                if (fill_level == 0) begin
                    res.status = deq_pkg::ST_RANGE;
                end else begin
                    res.data   = shadow_store[front_slot];
                    front_slot = (front_slot + 1) % DEPTH;
                    fill_level--;
                end
            end
            deq_pkg::OP_POP_BACK: begin
                if (fill_level == 0) begin
                    res.status = deq_pkg::ST_RANGE;
                end else begin
                    res.data = shadow_store[slot_of(fill_level - 1)];
                    fill_level--;
                end
            end
            deq_pkg::OP_READ_AT: begin
                if (pos >= fill_level) begin
                    res.status = deq_pkg::ST_RANGE;
                end else begin
                    res.data = shadow_store[slot_of(pos)];
                end
            end
            deq_pkg::OP_INSERT_AT: begin
                // range check wins over the full check
                if (pos > fill_level) begin
                    res.status = deq_pkg::ST_RANGE;
                end else if (fill_level >= DEPTH) begin
                    res.status = deq_pkg::ST_FULL;
                end else begin
                    for (k = fill_level; k > pos; k--)
                        shadow_store[slot_of(k)] = shadow_store[slot_of(k - 1)];
                    shadow_store[slot_of(pos)] = word;
                    fill_level++;
                end
            end
            deq_pkg::OP_ERASE_AT: begin
                if (pos >= fill_level) begin
                    res.status = deq_pkg::ST_RANGE;
                end else begin
                    res.data = shadow_store[slot_of(pos)];
                    for (k = pos; k + 1 < fill_level; k++)
                        shadow_store[slot_of(k)] = shadow_store[slot_of(k + 1)];
                    fill_level--;
                end
            end
            default: begin
                // unused code: no change
            end
        endcase
        res.count = CNT_W'(fill_level);
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        o_error_count++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // Predict on each accepted input word, compare on each accepted result
    always @(posedge i_clk) begin
        t_deque_result due;
        if (!i_rst_n) begin
            front_slot = 0;
            fill_level = 0;
            awaited_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                awaited_results.push_back(apply_deque_op(i_op, int'(i_position), i_data_in));
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result word with no input word awaiting it");
                end else begin
                    due = awaited_results.pop_front();
                    if (i_status !== due.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_status, due.status));
                    if (i_data_out !== due.data)
                        report_mismatch($sformatf("data_out %h, expected %h",
                                                  i_data_out, due.data));
                    if (i_count_out !== due.count)
                        report_mismatch($sformatf("count_out %0d, expected %0d",
                                                  i_count_out, due.count));
                end
            end
        end
        o_awaited    = awaited_results.size();
        o_fill_level = fill_level;
    end

endmodule

[test/double_ended_queue_tb.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Drives the deque with a directed opening (empty and boundary cases, every
// operation) and then random words biased to fill the store to capacity and
// drain it again, with random gaps and stalls on both channels. Results are
// checked by the companion checker; this module only makes stimulus.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH    = deq_pkg::DEPTH_DEF;
    localparam int DW       = deq_pkg::DATA_WIDTH_DEF;
    localparam int OP_W     = deq_pkg::OP_W;
    localparam int POS_W    = deq_pkg::POS_W;
    localparam int STATUS_W = deq_pkg::STATUS_W;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int N_RANDOM = 500;

    localparam logic [OP_W-1:0]      OP_UNUSED = 3'd7;
    localparam logic signed [DW-1:0] WORD_MIN  = 32'sh8000_0000;
    localparam logic signed [DW-1:0] WORD_MAX  = 32'sh7FFF_FFFF;

    typedef enum {MIX, FILL, DRAIN} t_bias;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 out_stall;
    logic [OP_W-1:0]      in_op;
    logic [POS_W-1:0]     in_position;
    logic signed [DW-1:0] in_data;
    wire                  in_stall;
    wire                  out_valid;
    wire [STATUS_W-1:0]   out_status;
    wire signed [DW-1:0]  out_data;
    wire [CNT_W-1:0]      out_count;
    int                   error_count;
    int                   awaited;
    int                   fill_level;

    double_ended_queue #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DW)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_op        (in_op),
        .i_position  (in_position),
        .i_data_in   (in_data),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_status    (out_status),
        .o_data_out  (out_data),
        .o_count_out (out_count)
    );

    double_ended_queue_chk #(
        .DEPTH (DEPTH),
        .DW    (DW)
    ) u_chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_op          (in_op),
        .i_position    (in_position),
        .i_data_in     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_status      (out_status),
        .i_data_out    (out_data),
        .i_count_out   (out_count),
        .o_error_count (error_count),
        .o_awaited     (awaited),
        .o_fill_level  (fill_level)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop for a hung run
    initial begin
        #40ms;
        $display("DONE: errors detected");
        $finish;
    end

    // Send one word after an optional idle gap; return at the falling edge after it is taken
    task automatic send_word(
        input logic [OP_W-1:0]      op,
        input logic [POS_W-1:0]     pos,
        input logic signed [DW-1:0] word,
        input int                   gap
    );
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        in_op       <= op;
        in_position <= pos;
        in_data     <= word;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // Hold the input side until every result word is back
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (awaited != 0);
    endtask

    // Output side stall: mostly short bursts, some long ones, some quiet stretches
    initial begin
        int   r;
        int   run;
        logic level;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                level = 1'b0;
                run   = $urandom_range(1, 12);
            end else if (r < 60) begin
                level = 1'b0;
                run   = $urandom_range(100, 300);
            end else if (r < 95) begin
                level = 1'b1;
                run   = $urandom_range(1, 3);
            end else begin
                level = 1'b1;
                run   = $urandom_range(20, 60);
            end
            repeat (run) begin
                @(negedge clk);
                out_stall <= level;
            end
        end
    end

    initial begin
        t_bias           bias;
        logic [OP_W-1:0] next_op;
        logic [POS_W-1:0] pos;
        logic signed [DW-1:0] word;
        int              counted;
        int              edge_hits;
        int              steady_left;
        int              gap;
        int              level;
        int              r;
        int              pick;
        bit              drained_once;
        bit              add_side;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_op       = deq_pkg::OP_PUSH_FRONT;
        in_position = '0;
        in_data     = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty queue: every removal and indexed access is out of range
        send_word(deq_pkg::OP_POP_FRONT, 8'd0, '0, 0);
        send_word(deq_pkg::OP_POP_BACK,  8'd0, '0, 1);
        send_word(deq_pkg::OP_READ_AT,   8'd0, '0, 0);
        send_word(deq_pkg::OP_ERASE_AT,  8'd0, '0, 0);
        send_word(deq_pkg::OP_INSERT_AT, 8'd1, '0, 2);
        // Insert at count on an empty queue appends
        send_word(deq_pkg::OP_INSERT_AT, 8'd0, WORD_MIN, 0);
        send_word(deq_pkg::OP_PUSH_BACK, 8'd0, WORD_MAX, 0);
        send_word(deq_pkg::OP_PUSH_FRONT, 8'd0, -32'sd1, 1);
        send_word(deq_pkg::OP_PUSH_FRONT, 8'd255, '0, 0);
        send_word(deq_pkg::OP_INSERT_AT, 8'd2, 32'sh1234_5678, 0);
        send_word(deq_pkg::OP_INSERT_AT, 8'd5, 32'sh55AA_55AA, 0);
        // Reads at both ends and beyond the count
        send_word(deq_pkg::OP_READ_AT, 8'd0, '0, 0);
        send_word(deq_pkg::OP_READ_AT, 8'd5, '0, 3);
        send_word(deq_pkg::OP_READ_AT, 8'd6, '0, 0);
        send_word(deq_pkg::OP_READ_AT, 8'd255, WORD_MAX, 0);
        send_word(OP_UNUSED, 8'd170, 32'shDEAD_BEEF, 0);
        // Erase in the middle, at the front, at the back, and beyond the count
        send_word(deq_pkg::OP_ERASE_AT, 8'd2, '0, 0);
        send_word(deq_pkg::OP_ERASE_AT, 8'd0, '0, 1);
        send_word(deq_pkg::OP_ERASE_AT, 8'd3, '0, 0);
        send_word(deq_pkg::OP_ERASE_AT, 8'd255, '0, 0);
        send_word(deq_pkg::OP_POP_BACK, 8'd0, '0, 0);
        send_word(deq_pkg::OP_POP_FRONT, 8'd0, '0, 0);
        send_word(deq_pkg::OP_INSERT_AT, 8'd0, 32'shAAAA_AAAA, 0);
        hold_until_drained();

        // Random words: mixed, then fill to capacity, then drain to empty
        bias         = MIX;
        counted      = 0;
        edge_hits    = 0;
        steady_left  = 0;
        drained_once = 1'b0;
        while (counted < N_RANDOM || !drained_once) begin
            level = fill_level;
            case (bias)
                MIX: begin
                    if (!drained_once && counted >= 20)
                        bias = FILL;
                end
                FILL: begin
                    if (level == DEPTH) begin
                        edge_hits++;
                        if (edge_hits > 8) begin
                            hold_until_drained();
                            bias      = DRAIN;
                            edge_hits = 0;
                        end
                    end
                end
                DRAIN: begin
                    if (level == 0) begin
                        edge_hits++;
                        if (edge_hits > 6) begin
                            bias         = MIX;
                            drained_once = 1'b1;
                            edge_hits    = 0;
                        end
                    end
                end
                default: ;
            endcase

            // Pick the operation, weighted by the current bias
            r = $urandom_range(0, 99);
            if (r < 3) begin
                next_op = OP_UNUSED;
            end else if (bias == MIX) begin
                next_op = OP_W'($urandom_range(0, 6));
            end else if (r < 98) begin
                add_side = (bias == FILL) == (r < 97);
                pick     = $urandom_range(0, 2);
                if (add_side)
                    next_op = (pick == 0) ? deq_pkg::OP_PUSH_FRONT :
                              (pick == 1) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_INSERT_AT;
                else
                    next_op = (pick == 0) ? deq_pkg::OP_POP_FRONT :
                              (pick == 1) ? deq_pkg::OP_POP_BACK : deq_pkg::OP_ERASE_AT;
            end else begin
                next_op = deq_pkg::OP_READ_AT;
            end

            // Positions mostly in range, sometimes anywhere
            if (next_op == deq_pkg::OP_INSERT_AT && $urandom_range(0, 99) < 85)
                pos = POS_W'($urandom_range(0, (level < 255) ? level : 255));
            else if ((next_op == deq_pkg::OP_READ_AT || next_op == deq_pkg::OP_ERASE_AT)
                     && level > 0 && $urandom_range(0, 99) < 85)
                pos = POS_W'($urandom_range(0, level - 1));
            else
                pos = POS_W'($urandom_range(0, 255));

            if ($urandom_range(0, 99) < 10) begin
                case ($urandom_range(0, 3))
                    0:       word = WORD_MIN;
                    1:       word = WORD_MAX;
                    2:       word = '0;
                    default: word = -32'sd1;
                endcase
            end else begin
                word = DW'($urandom());
            end

            // Sender gaps: mostly none or short, a few long, some steady runs
            if (steady_left > 0) begin
                steady_left--;
                gap = 0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 5)       begin steady_left = $urandom_range(20, 40); gap = 0; end
                else if (r < 60) gap = 0;
                else if (r < 88) gap = $urandom_range(1, 3);
                else if (r < 97) gap = $urandom_range(4, 10);
                else             gap = $urandom_range(20, 60);
            end

            send_word(next_op, pos, word, gap);
            if (next_op != OP_UNUSED)
                counted++;
        end

        hold_until_drained();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
